// ===== src/bfb_pkg.sv =====
package bfb_pkg;

    // default longest ssid and fixed frame geometry
    localparam int SSID_MAX_DEF = 32;
    localparam int SFX_MIN      = 4;
    localparam int HEAD_LEN     = 38;
    localparam int TAIL_LEN     = 13;
    localparam int FIXED_LEN    = HEAD_LEN + TAIL_LEN;

    // widths that cover the whole ssid_max range
    localparam int NAME_LEN_W = 5;
    localparam int SSID_LEN_W = 6;

    // suffix characters
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    // request kinds
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_BUILD = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_BYTES
    } bfb_state_t;

    // per-frame values latched on a build request
    typedef struct packed {
        logic [47:0]           mac;
        logic [11:0]           seq;
        logic [7:0]            channel;
        logic [5:0][7:0]       sfx;
        logic [2:0]            sfx_len;
        logic [NAME_LEN_W-1:0] name_len;
        logic [SSID_LEN_W-1:0] tag_len;
    } frame_par_t;

    // name store status
    typedef struct packed {
        logic [NAME_LEN_W-1:0] stored_cnt;
        logic [NAME_LEN_W-1:0] trimmed_len;
        logic                  seen;
    } name_stat_t;

    function automatic logic is_blank(input logic [7:0] b);
        is_blank = (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0d));
    endfunction

    // rates tag followed by the channel tag header
    function automatic logic [7:0] tail_byte(input logic [3:0] i);
        logic [7:0] b;
        case (i)
            4'd0:    b = 8'h01;
            4'd1:    b = 8'h08;
            4'd2:    b = 8'h82;
            4'd3:    b = 8'h84;
            4'd4:    b = 8'h8b;
            4'd5:    b = 8'h96;
            4'd6:    b = 8'h24;
            4'd7:    b = 8'h30;
            4'd8:    b = 8'h48;
            4'd9:    b = 8'h6c;
            4'd10:   b = 8'h03;
            4'd11:   b = 8'h01;
            default: b = 8'h00;
        endcase
        tail_byte = b;
    endfunction

endpackage

// ===== src/beacon_frame_builder_unit.sv =====
// channel   dir  tdata / tuser / tlast
// s_axis    in   tdata: name_byte, station_mac, progress_pct, radio_channel; tuser: req_type
// m_axis    out  tdata: frame_word, byte_count; tlast: last_word
//
// a name byte load gives no output transaction
// a build latches its values, then gives one frame byte per cycle while the
// output does not stall (51 + ssid length bytes, 55 to 83 at the default ssid
// limit); the single read port of the name memory sets that byte rate
// input is held off for the whole build; a full output register stalls the
// byte sequencer only when the next word is complete
// reset clears the name store counts, the state and the sequence number; the
// name memory needs no clearing pass, entries are used only below the stored count
module beacon_frame_builder_unit
    import bfb_pkg::*;
#(
    parameter int SSID_MAX = SSID_MAX_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] name_byte, [55:8] station_mac, [62:56] progress_pct,
    // [70:63] radio_channel, [71] zero
    input  logic [71:0] s_axis_tdata,
    // [0] req_type
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] frame_word, [34:32] byte_count, [39:35] zero
    output logic [39:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    localparam int NAME_CAP = SSID_MAX - SFX_MIN;
    localparam int AW       = $clog2(NAME_CAP);
    localparam int POS_W    = $clog2(FIXED_LEN + SSID_MAX);

    // store control from the sequencer
    logic             load_en;
    logic [7:0]       load_byte;
    logic             name_clear;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [7:0]       rd_data;
    name_stat_t       name_stat;

    // byte sequencer to byte source
    frame_par_t       par;
    logic [POS_W-1:0] pos;
    logic [7:0]       frame_byte;

    logic [31:0]      frame_word;
    logic [2:0]       byte_count;

    bfb_name_store #(
        .SSID_MAX (SSID_MAX)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .load_en   (load_en),
        .load_byte (load_byte),
        .clear     (name_clear),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .stat      (name_stat)
    );

    bfb_byte_src #(
        .SSID_MAX (SSID_MAX)
    ) u_src (
        .pos        (pos),
        .par        (par),
        .name_data  (rd_data),
        .frame_byte (frame_byte)
    );

    bfb_frame_ctrl #(
        .SSID_MAX (SSID_MAX)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .req_type      (s_axis_tuser),
        .name_byte     (s_axis_tdata[7:0]),
        .station_mac   (s_axis_tdata[55:8]),
        .progress_pct  (s_axis_tdata[62:56]),
        .radio_channel (s_axis_tdata[70:63]),
        .stat          (name_stat),
        .load_en       (load_en),
        .load_byte     (load_byte),
        .clear         (name_clear),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .par           (par),
        .pos           (pos),
        .frame_byte    (frame_byte),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .frame_word    (frame_word),
        .byte_count    (byte_count),
        .last_word     (m_axis_tlast)
    );

    assign m_axis_tdata = {5'b0, byte_count, frame_word};

    // every word but the last is full
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> byte_count == 3'd4)
        else $error("short word before end of frame");

    // every word carries one to four bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (byte_count != 3'd0) && (byte_count <= 3'd4))
        else $error("byte count out of range");

    // trimmed length never passes the stored count
    assert property (@(posedge clk) disable iff (!rst_n)
        name_stat.trimmed_len <= name_stat.stored_cnt)
        else $error("trimmed length beyond stored bytes");

    // the name store is empty after a frame completes
    assert property (@(posedge clk) disable iff (!rst_n)
        name_clear |=> (name_stat.stored_cnt == '0) && !name_stat.seen)
        else $error("name store not cleared after build");

    // no transaction is taken while a build is running
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_BUILD) |=> !s_axis_tready)
        else $error("input taken during frame build");

endmodule

// ===== src/bfb_name_store.sv =====
module bfb_name_store
    import bfb_pkg::*;
#(
    parameter int SSID_MAX = SSID_MAX_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load_en,
    input  logic [7:0]                          load_byte,
    input  logic                                clear,
    input  logic                                rd_en,
    input  logic [$clog2(SSID_MAX-SFX_MIN)-1:0] rd_addr,
    output logic [7:0]                          rd_data,
    output name_stat_t                          stat
);

    localparam int NAME_CAP = SSID_MAX - SFX_MIN;
    localparam int AW       = $clog2(NAME_CAP);

    logic [7:0] mem [NAME_CAP];

    logic [NAME_LEN_W-1:0] stored_cnt_reg;
    logic [NAME_LEN_W-1:0] stored_cnt_next;
    logic [NAME_LEN_W-1:0] trimmed_len_reg;
    logic [NAME_LEN_W-1:0] trimmed_len_next;
    logic                  seen_reg;
    logic                  seen_next;
    logic [7:0]            rd_data_reg;
    logic                  blank;
    logic                  keep;
    logic                  room;

    assign blank = is_blank(load_byte);
    // leading whitespace is dropped
    assign keep  = load_en && (seen_reg || !blank);
    assign room  = stored_cnt_reg < NAME_LEN_W'(NAME_CAP);

    always_comb
    begin
        stored_cnt_next  = stored_cnt_reg;
        trimmed_len_next = trimmed_len_reg;
        seen_next        = seen_reg;
        if (clear)
        begin
            stored_cnt_next  = '0;
            trimmed_len_next = '0;
            seen_next        = 1'b0;
        end
        else if (keep)
        begin
            seen_next = 1'b1;
            if (room)
            begin
                stored_cnt_next = stored_cnt_reg + 1'b1;
            end
            if (!blank)
            begin
                trimmed_len_next = stored_cnt_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_cnt_reg  <= '0;
            trimmed_len_reg <= '0;
            seen_reg        <= 1'b0;
        end
        else
        begin
            stored_cnt_reg  <= stored_cnt_next;
            trimmed_len_reg <= trimmed_len_next;
            seen_reg        <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (keep && room)
        begin
            mem[stored_cnt_reg[AW-1:0]] <= load_byte;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data          = rd_data_reg;
    assign stat.stored_cnt  = stored_cnt_reg;
    assign stat.trimmed_len = trimmed_len_reg;
    assign stat.seen        = seen_reg;

endmodule

// ===== src/bfb_byte_src.sv =====
module bfb_byte_src
    import bfb_pkg::*;
#(
    parameter int SSID_MAX = SSID_MAX_DEF
)
(
    input  logic [$clog2(FIXED_LEN+SSID_MAX)-1:0] pos,
    input  frame_par_t                            par,
    input  logic [7:0]                            name_data,
    output logic [7:0]                            frame_byte
);

    localparam int POS_W = $clog2(FIXED_LEN + SSID_MAX);

    logic [5:0]       hp;
    logic [2:0]       mi;
    logic [7:0]       mac_b;
    logic [7:0]       head_b;
    logic [POS_W-1:0] rel;
    logic [POS_W-1:0] sp;
    logic [POS_W-1:0] tp;

    assign hp = pos[5:0];

    always_comb
    begin
        // source address and bssid both carry the mac
        mi     = (hp < 6'd16) ? 3'(hp - 6'd10) : 3'(hp - 6'd16);
        mac_b  = par.mac[8*mi +: 8];
        case (hp)
            6'd0:                                 head_b = 8'h80;
            6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd9:   head_b = 8'hff;
            6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15,
            6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21:
                                                  head_b = mac_b;
            6'd22:                                head_b = {par.seq[3:0], 4'h0};
            6'd23:                                head_b = par.seq[11:4];
            6'd32:                                head_b = 8'h64;
            6'd34:                                head_b = 8'h01;
            6'd35:                                head_b = 8'h04;
            6'd37:                                head_b = 8'(par.tag_len);
            default:                              head_b = 8'h00;
        endcase
    end

    always_comb
    begin
        rel = pos - POS_W'(HEAD_LEN);
        sp  = rel - POS_W'(par.name_len);
        tp  = sp - POS_W'(par.sfx_len);
        if (pos < POS_W'(HEAD_LEN))
        begin
            frame_byte = head_b;
        end
        else if (rel < POS_W'(par.name_len))
        begin
            frame_byte = name_data;
        end
        else if (sp < POS_W'(par.sfx_len))
        begin
            frame_byte = par.sfx[sp[2:0]];
        end
        else if (tp == POS_W'(TAIL_LEN - 1))
        begin
            frame_byte = par.channel;
        end
        else
        begin
            frame_byte = tail_byte(tp[3:0]);
        end
    end

endmodule

// ===== src/bfb_frame_ctrl.sv =====
module bfb_frame_ctrl
    import bfb_pkg::*;
#(
    parameter int SSID_MAX = SSID_MAX_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  req_type,
    input  logic [7:0]                            name_byte,
    input  logic [47:0]                           station_mac,
    input  logic [6:0]                            progress_pct,
    input  logic [7:0]                            radio_channel,
    input  name_stat_t                            stat,
    output logic                                  load_en,
    output logic [7:0]                            load_byte,
    output logic                                  clear,
    output logic                                  rd_en,
    output logic [$clog2(SSID_MAX-SFX_MIN)-1:0]   rd_addr,
    output frame_par_t                            par,
    output logic [$clog2(FIXED_LEN+SSID_MAX)-1:0] pos,
    input  logic [7:0]                            frame_byte,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [31:0]                           frame_word,
    output logic [2:0]                            byte_count,
    output logic                                  last_word
);

    localparam int NAME_CAP = SSID_MAX - SFX_MIN;
    localparam int AW       = $clog2(NAME_CAP);
    localparam int POS_W    = $clog2(FIXED_LEN + SSID_MAX);

    bfb_state_t       state_reg;
    bfb_state_t       state_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [POS_W-1:0] last_pos_reg;
    logic [POS_W-1:0] last_pos_next;
    frame_par_t       par_reg;
    frame_par_t       par_next;
    logic [15:0]      seq_reg;
    logic [15:0]      seq_next;
    logic [23:0]      word_reg;
    logic [23:0]      word_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [31:0]      out_word_reg;
    logic [31:0]      out_word_next;
    logic [2:0]       out_cnt_reg;
    logic [2:0]       out_cnt_next;
    logic             out_last_reg;
    logic             out_last_next;

    // suffix digits, tens taken by a reciprocal multiply
    logic [6:0]            pct_sat;
    logic [14:0]           pct_prod;
    logic [3:0]            tens_full;
    logic [3:0]            tens_dig;
    logic [3:0]            ones_dig;
    logic [2:0]            sfx_len;
    logic [5:0]            name_lim;
    logic [NAME_LEN_W-1:0] name_len;

    logic [1:0]       lane;
    logic             at_last;
    logic             word_done;
    logic             stall;
    logic [31:0]      word_full;
    logic [POS_W-1:0] rd_rel;

    always_comb
    begin
        pct_sat   = (progress_pct > 7'd100) ? 7'd100 : progress_pct;
        pct_prod  = 15'(pct_sat) * 15'd205;
        tens_full = pct_prod[14:11];
        ones_dig  = 4'(pct_sat - 7'(tens_full) * 7'd10);
        tens_dig  = (tens_full == 4'd10) ? 4'd0 : tens_full;
        if (pct_sat == 7'd100)
        begin
            sfx_len = 3'd6;
        end
        else if (pct_sat >= 7'd10)
        begin
            sfx_len = 3'd5;
        end
        else
        begin
            sfx_len = 3'd4;
        end
        name_lim = 6'(SSID_MAX) - 6'(sfx_len);
        name_len = (6'(stat.trimmed_len) < name_lim) ? stat.trimmed_len
                                                     : NAME_LEN_W'(name_lim);

        par_next          = par_reg;
        par_next.mac      = station_mac;
        par_next.seq      = seq_reg[11:0];
        par_next.channel  = radio_channel;
        par_next.sfx_len  = sfx_len;
        par_next.name_len = name_len;
        par_next.tag_len  = SSID_LEN_W'(name_len) + SSID_LEN_W'(sfx_len);
        par_next.sfx[0]   = CH_COLON;
        par_next.sfx[1]   = CH_SPACE;
        par_next.sfx[5]   = 8'h00;
        case (sfx_len)
            3'd6:
            begin
                par_next.sfx[2] = CH_ZERO + 8'd1;
                par_next.sfx[3] = CH_ZERO + 8'(tens_dig);
                par_next.sfx[4] = CH_ZERO + 8'(ones_dig);
                par_next.sfx[5] = CH_PCT;
            end
            3'd5:
            begin
                par_next.sfx[2] = CH_ZERO + 8'(tens_dig);
                par_next.sfx[3] = CH_ZERO + 8'(ones_dig);
                par_next.sfx[4] = CH_PCT;
            end
            default:
            begin
                par_next.sfx[2] = CH_ZERO + 8'(ones_dig);
                par_next.sfx[3] = CH_PCT;
                par_next.sfx[4] = 8'h00;
            end
        endcase
    end

    assign lane      = pos_reg[1:0];
    assign at_last   = (pos_reg == last_pos_reg);
    assign word_done = (lane == 2'd3) || at_last;
    // a finished word waits only if the output register is still held
    assign stall     = word_done && out_valid_reg && !out_ready;

    always_comb
    begin
        word_full              = (lane == 2'd0) ? 32'h0 : {8'h00, word_reg};
        word_full[8*lane +: 8] = frame_byte;
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        last_pos_next  = last_pos_reg;
        seq_next       = seq_reg;
        word_next      = word_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_word_next  = out_word_reg;
        out_cnt_next   = out_cnt_reg;
        out_last_next  = out_last_reg;
        in_ready       = 1'b0;
        load_en        = 1'b0;
        clear          = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (req_type == REQ_LOAD)
                    begin
                        load_en = 1'b1;
                    end
                    else
                    begin
                        pos_next      = '0;
                        last_pos_next = POS_W'(FIXED_LEN - 1) + POS_W'(par_next.tag_len);
                        state_next    = ST_BYTES;
                    end
                end
            end
            ST_BYTES:
            begin
                if (!stall)
                begin
                    word_next = word_full[23:0];
                    pos_next  = pos_reg + 1'b1;
                    if (word_done)
                    begin
                        out_valid_next = 1'b1;
                        out_word_next  = word_full;
                        out_cnt_next   = 3'(lane) + 3'd1;
                        out_last_next  = at_last;
                    end
                    if (at_last)
                    begin
                        pos_next   = pos_reg;
                        clear      = 1'b1;
                        seq_next   = seq_reg + 16'd1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // name bytes are fetched in the cycle before their frame position
    always_comb
    begin
        rd_rel  = pos_next - POS_W'(HEAD_LEN);
        rd_en   = (pos_next >= POS_W'(HEAD_LEN)) && (rd_rel < POS_W'(NAME_CAP));
        rd_addr = rd_rel[AW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seq_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seq_reg       <= seq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && in_valid && (req_type == REQ_BUILD))
        begin
            par_reg <= par_next;
        end
        pos_reg      <= pos_next;
        last_pos_reg <= last_pos_next;
        word_reg     <= word_next;
        out_word_reg <= out_word_next;
        out_cnt_reg  <= out_cnt_next;
        out_last_reg <= out_last_next;
    end

    assign load_byte  = name_byte;
    assign par        = par_reg;
    assign pos        = pos_reg;
    assign out_valid  = out_valid_reg;
    assign frame_word = out_word_reg;
    assign byte_count = out_cnt_reg;
    assign last_word  = out_last_reg;

endmodule
